FILE: rtl/rpw_pkg.sv
// shared types, widths and constants for the radar polar-to-world converter
// no dependencies
package rpw_pkg;

    localparam int RANGE_W   = 18;
    localparam int ANGLE_W   = 16;
    localparam int OFS_W     = 24;
    localparam int HGT_W     = 16;
    localparam int WORLD_W   = 25;
    localparam int SQ_IN_W   = 2 * RANGE_W;
    localparam int REM_W     = RANGE_W + 2;
    localparam int XY_W      = 52;
    localparam int Z_W       = 34;
    localparam int STEPS_DEF = 16;
    localparam int STEPS_MAX = 32;

    localparam logic [1:0] REG_OFS_X  = 2'd0;
    localparam logic [1:0] REG_OFS_Y  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_YAW    = 2'd3;

    localparam logic [33:0] ANG_SCALE    = 34'd12281662764;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    // travels alongside the data through every cell
    typedef struct packed {
        logic                  valid;
        logic                  below;
        logic                  neg;
        logic signed [Z_W-1:0] z;
    } side_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd7;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/rpw_sqrt_cell.sv
// one digit of the restoring integer square root, two radicand bits per cell
// depends on rpw_pkg
module rpw_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ce,
    input  rpw_pkg::side_t                     side_in,
    input  logic [rpw_pkg::SQ_IN_W-1:0]        rad_in,
    input  logic [rpw_pkg::REM_W-1:0]          rem_in,
    input  logic [rpw_pkg::RANGE_W-1:0]        root_in,
    output rpw_pkg::side_t                     side_out,
    output logic [rpw_pkg::SQ_IN_W-1:0]        rad_out,
    output logic [rpw_pkg::REM_W-1:0]          rem_out,
    output logic [rpw_pkg::RANGE_W-1:0]        root_out
);
    import rpw_pkg::*;

    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W-1:0]   rem_next;
    logic [RANGE_W-1:0] root_next;
    side_t              side_reg;
    logic [SQ_IN_W-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [RANGE_W-1:0] root_reg;

    always_comb
    begin
        rem_sh = {rem_in, rad_in[SQ_IN_W-1-2*IDX -: 2]};
        trial  = {2'b00, root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = REM_W'(rem_sh - trial);
            root_next = {root_in[RANGE_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_W'(rem_sh);
            root_next = {root_in[RANGE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (ce)
            side_reg <= side_in;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rad_reg        <= rad_in;
            rem_reg        <= rem_next;
            root_reg       <= root_next;
        end
    end

    assign side_out = side_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

FILE: rtl/rpw_cordic_cell.sv
// one rotation-mode cordic iteration with a fixed shift of IDX
// depends on rpw_pkg
module rpw_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ce,
    input  rpw_pkg::side_t                     side_in,
    input  logic signed [rpw_pkg::XY_W-1:0]    x_in,
    input  logic signed [rpw_pkg::XY_W-1:0]    y_in,
    output rpw_pkg::side_t                     side_out,
    output logic signed [rpw_pkg::XY_W-1:0]    x_out,
    output logic signed [rpw_pkg::XY_W-1:0]    y_out
);
    import rpw_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q30(IDX));

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    side_t                  side_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;

    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!side_in.z[Z_W-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = side_in.z - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = side_in.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (ce)
        begin
            side_reg.valid <= side_in.valid;
            side_reg.below <= side_in.below;
            side_reg.neg   <= side_in.neg;
            side_reg.z     <= z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg          <= x_next;
            y_reg          <= y_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
endmodule

FILE: rtl/radar_polar_to_world_xy_top.sv
// radar detection (slant range, bearing) to world x/y with height and mount pose
// depends on rpw_pkg, rpw_sqrt_cell, rpw_cordic_cell
//
// usage
//   s_* channel: one detection per word, tdata = {bearing_cdeg, range_mm}
//   m_* channel: one result per detection, tdata = {world_y_mm, world_x_mm},
//   tuser = below_height (range shorter than mounting height, distance clamped)
//   wr_en/wr_addr/wr_data: register writes, only while no detection is in flight
// pipeline: 2 front stages, 18 square-root cells, 1 gain multiply,
//   CORDIC_STEPS rotation cells (at most STEPS_MAX) and 1 output register
// throughput: one word per cycle unless stalled; the whole pipe is a chain of cells
//   that advance together, one cell per square-root digit and per cordic iteration
// stall: while m_tvalid is high and m_tready low the whole chain holds and
//   s_tready drops; empty slots inside the chain are not squeezed out
// reset: pipe empties, offsets and yaw go to 0, mounting height to 4000 mm
module radar_polar_to_world_xy_top #(
    parameter int CORDIC_STEPS = rpw_pkg::STEPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [39:0]               s_tdata,   // range_mm[17:0], bearing_cdeg[33:18]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // world_x_mm[24:0], world_y_mm[49:25]
    output logic                      m_tuser,   // below_height
    input  logic                      wr_en,
    input  logic [1:0]                wr_addr,
    input  logic [rpw_pkg::OFS_W-1:0] wr_data
);
    import rpw_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > STEPS_MAX) ? STEPS_MAX : CORDIC_STEPS;

    // configuration registers
    logic signed [OFS_W-1:0]   ofs_x_reg;
    logic signed [OFS_W-1:0]   ofs_y_reg;
    logic [HGT_W-1:0]          height_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_x_reg  <= '0;
            ofs_y_reg  <= '0;
            height_reg <= HGT_W'(4000);
            yaw_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_addr)
                REG_OFS_X:  ofs_x_reg  <= wr_data;
                REG_OFS_Y:  ofs_y_reg  <= wr_data;
                REG_HEIGHT: height_reg <= wr_data[HGT_W-1:0];
                REG_YAW:    yaw_reg    <= wr_data[ANGLE_W-1:0];
                default:    ;
            endcase
        end
    end

    // whole chain advances when the output slot is free or being taken
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // front stage 0: squares, below flag, angle wrap and fold
    logic [RANGE_W-1:0]         rng;
    logic signed [ANGLE_W-1:0]  brg;
    logic [RANGE_W:0]           wrap_v;
    logic [RANGE_W:0]           wrap_m;
    logic signed [ANGLE_W-1:0]  ang;
    logic signed [ANGLE_W-1:0]  ang_f;
    logic                       neg_f;

    assign rng = s_tdata[RANGE_W-1:0];
    assign brg = s_tdata[RANGE_W+ANGLE_W-1:RANGE_W];

    always_comb
    begin
        // always positive here: bearing - yaw + 90000 lies in 24465..155535
        wrap_v = (RANGE_W+1)'(32'(signed'(brg)) - 32'(signed'(yaw_reg)) + 32'sd90000);
        if (wrap_v >= (RANGE_W+1)'(144000))
            wrap_m = wrap_v - (RANGE_W+1)'(144000);
        else if (wrap_v >= (RANGE_W+1)'(108000))
            wrap_m = wrap_v - (RANGE_W+1)'(108000);
        else if (wrap_v >= (RANGE_W+1)'(72000))
            wrap_m = wrap_v - (RANGE_W+1)'(72000);
        else if (wrap_v >= (RANGE_W+1)'(36000))
            wrap_m = wrap_v - (RANGE_W+1)'(36000);
        else
            wrap_m = wrap_v;
        ang = ANGLE_W'(signed'({1'b0, wrap_m}) - 20'sd18000);
        // fold into +-90 degrees, negate both outputs afterwards
        if (ang > 16'sd9000)
        begin
            ang_f = ang - 16'sd18000;
            neg_f = 1'b1;
        end
        else if (ang < -16'sd9000)
        begin
            ang_f = ang + 16'sd18000;
            neg_f = 1'b1;
        end
        else
        begin
            ang_f = ang;
            neg_f = 1'b0;
        end
    end

    logic                      f0_valid_reg;
    logic [SQ_IN_W-1:0]        f0_rr_reg;
    logic [2*HGT_W-1:0]        f0_hh_reg;
    logic                      f0_below_reg;
    logic                      f0_neg_reg;
    logic signed [ANGLE_W-1:0] f0_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f0_valid_reg <= 1'b0;
        else if (ce)
            f0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f0_rr_reg    <= rng * rng;
            f0_hh_reg    <= height_reg * height_reg;
            f0_below_reg <= ({2'b00, rng} < {2'b00, height_reg});
            f0_neg_reg   <= neg_f;
            f0_ang_reg   <= ang_f;
        end
    end

    // front stage 1: radicand and angle to q30 radians
    logic [ANGLE_W-2:0] ang_abs;
    logic [47:0]        ang_prod;
    logic [31:0]        z_mag;
    logic [SQ_IN_W-1:0] rad_next;

    always_comb
    begin
        ang_abs  = (ANGLE_W-1)'(f0_ang_reg[ANGLE_W-1] ? -f0_ang_reg : f0_ang_reg);
        ang_prod = 48'(ang_abs) * 48'(ANG_SCALE) + 48'd32768;
        z_mag    = ang_prod[47:16];
        rad_next = f0_below_reg ? '0 : f0_rr_reg - SQ_IN_W'(f0_hh_reg);
    end

    side_t              f1_side_reg;
    logic [SQ_IN_W-1:0] f1_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_side_reg <= '0;
        else if (ce)
        begin
            f1_side_reg.valid <= f0_valid_reg;
            f1_side_reg.below <= f0_below_reg;
            f1_side_reg.neg   <= f0_neg_reg;
            f1_side_reg.z     <= f0_ang_reg[ANGLE_W-1] ? -Z_W'(z_mag) : Z_W'(z_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            f1_rad_reg        <= rad_next;
    end

    // square-root chain, one result bit per cell
    side_t              sq_side [RANGE_W+1];
    logic [SQ_IN_W-1:0] sq_rad  [RANGE_W+1];
    logic [REM_W-1:0]   sq_rem  [RANGE_W+1];
    logic [RANGE_W-1:0] sq_root [RANGE_W+1];

    assign sq_side[0] = f1_side_reg;
    assign sq_rad[0]  = f1_rad_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < RANGE_W; g++)
    begin : g_sqrt
        rpw_sqrt_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ce       (ce),
            .side_in  (sq_side[g]),
            .rad_in   (sq_rad[g]),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .side_out (sq_side[g+1]),
            .rad_out  (sq_rad[g+1]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1])
        );
    end

    // gain-compensated start vector x0 = d / gain in q30
    side_t                  g_side_reg;
    logic signed [XY_W-1:0] g_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_side_reg <= '0;
        else if (ce)
            g_side_reg <= sq_side[RANGE_W];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            g_x_reg          <= signed'(XY_W'(sq_root[RANGE_W]) * XY_W'(INV_GAIN_Q30));
    end

    // cordic chain
    side_t                  cd_side [NSTEP+1];
    logic signed [XY_W-1:0] cd_x    [NSTEP+1];
    logic signed [XY_W-1:0] cd_y    [NSTEP+1];

    assign cd_side[0] = g_side_reg;
    assign cd_x[0]    = g_x_reg;
    assign cd_y[0]    = '0;

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_cordic
        rpw_cordic_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ce       (ce),
            .side_in  (cd_side[g]),
            .x_in     (cd_x[g]),
            .y_in     (cd_y[g]),
            .side_out (cd_side[g+1]),
            .x_out    (cd_x[g+1]),
            .y_out    (cd_y[g+1])
        );
    end

    // rounding, sign fix and offset
    localparam logic signed [XY_W-1:0] HALF = XY_W'(1) <<< 29;

    logic signed [XY_W-1:0]    y_rnd;
    logic signed [XY_W-1:0]    x_rnd;
    logic signed [WORLD_W-1:0] sv;
    logic signed [WORLD_W-1:0] cv;
    logic signed [WORLD_W-1:0] wx_next;
    logic signed [WORLD_W-1:0] wy_next;

    always_comb
    begin
        y_rnd = (cd_y[NSTEP] + HALF) >>> 30;
        x_rnd = (cd_x[NSTEP] + HALF) >>> 30;
        sv    = WORLD_W'(y_rnd);
        cv    = WORLD_W'(x_rnd);
        if (cd_side[NSTEP].neg)
        begin
            sv = -sv;
            cv = -cv;
        end
        wx_next = sv + WORLD_W'(ofs_x_reg);
        wy_next = cv + WORLD_W'(ofs_y_reg);
    end

    logic                      out_valid_reg;
    logic signed [WORLD_W-1:0] out_x_reg;
    logic signed [WORLD_W-1:0] out_y_reg;
    logic                      out_below_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= cd_side[NSTEP].valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_x_reg     <= wx_next;
            out_y_reg     <= wy_next;
            out_below_reg <= cd_side[NSTEP].below;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_y_reg, out_x_reg};
    assign m_tuser  = out_below_reg;

`ifndef SYNTHESIS
    // a clamped detection lands exactly on the mounting offset
    a_below_at_offset : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_below_reg) |->
            (out_x_reg == WORLD_W'(ofs_x_reg)) && (out_y_reg == WORLD_W'(ofs_y_reg)))
        else $error("clamped detection not at mounting offset");

    // an accepted word enters the first stage
    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> f0_valid_reg)
        else $error("accepted word lost at pipe entry");

    // a stalled chain keeps the last cordic stage in place
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(cd_side[NSTEP]) && $stable(cd_x[NSTEP]))
        else $error("cordic chain moved during stall");

    // clamped words carry a zero radicand into the root chain
    a_below_zero_root : assert property (@(posedge clk) disable iff (!rst_n)
        (sq_side[RANGE_W].valid && sq_side[RANGE_W].below) |-> (sq_root[RANGE_W] == '0))
        else $error("clamped detection has nonzero ground distance");
`endif
endmodule

FILE: dv/radar_polar_to_world_xy_top_test.sv
// testbench for the radar polar-to-world converter: random and directed detections
// checked against a built-in cordic predictor; depends on rpw_pkg and the top level
`timescale 1ns / 100ps

module radar_polar_to_world_xy_top_test;

    import rpw_pkg::*;

    localparam int STEPS   = 16;
    localparam int LATENCY = 22 + STEPS;
    localparam int WD_MAX  = 2000;

    typedef struct packed {
        logic [ANGLE_W-1:0] bearing;
        logic [RANGE_W-1:0] range_mm;
    } detection_t;

    typedef struct packed {
        logic [WORLD_W-1:0] wx;
        logic [WORLD_W-1:0] wy;
        logic               below;
    } world_pt_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [55:0]        m_tdata;
    logic               m_tuser;
    logic               wr_en;
    logic [1:0]         wr_addr;
    logic [OFS_W-1:0]   wr_data;

    // register shadow used by the predictor
    logic signed [OFS_W-1:0]   ofs_x;
    logic signed [OFS_W-1:0]   ofs_y;
    logic [HGT_W-1:0]          height;
    logic signed [ANGLE_W-1:0] yaw;

    detection_t pending_dets[$];
    world_pt_t  expected_pts[$];
    int         fail_count;
    int         idle_cycles;

    // accept flag seen at the last rising edge
    logic s_tready_q;
    int   gap_left;
    int   stall_left;

    radar_polar_to_world_xy_top #(.CORDIC_STEPS(STEPS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // floor shift for signed 64-bit values
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tbl(input int i);
        longint t[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                          524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                          2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
        return t[i];
    endfunction

    function automatic longint ground_dist(input longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // expected world point for one detection under the current mount pose
    function automatic world_pt_t locate(input detection_t det);
        world_pt_t pt;
        longint r, h, d, a, z, x, y, xs, ys, sv, cv;
        bit     flip;
        r = det.range_mm;
        h = height;
        d = 0;
        flip = 0;
        pt.below = (r < h);
        if (!pt.below)
            d = ground_dist(r * r - h * h);
        a = ((longint'($signed(det.bearing)) - longint'(yaw)) + 90000) % 36000 - 18000;
        if (a > 9000)
        begin
            a = a - 18000;
            flip = 1;
        end
        else if (a < -9000)
        begin
            a = a + 18000;
            flip = 1;
        end
        if (a < 0)
            z = -(((-a) * 64'sd12281662764 + 32768) >> 16);
        else
            z = (a * 64'sd12281662764 + 32768) >> 16;
        x = d * 64'sd652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tbl(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tbl(i);
            end
        end
        sv = fshr(y + (64'sd1 << 29), 30);
        cv = fshr(x + (64'sd1 << 29), 30);
        if (flip)
        begin
            sv = -sv;
            cv = -cv;
        end
        pt.wx = WORLD_W'(sv + longint'(ofs_x));
        pt.wy = WORLD_W'(cv + longint'(ofs_y));
        return pt;
    endfunction

    // register write, called only while the pipe is empty
    task automatic write_reg(input logic [1:0] idx, input logic [OFS_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_addr <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_OFS_X:  ofs_x = val;
            REG_OFS_Y:  ofs_y = val;
            REG_HEIGHT: height = val[HGT_W-1:0];
            REG_YAW:    yaw = val[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_dets.size() != 0 || expected_pts.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic detection_t rand_det(input logic [HGT_W-1:0] h);
        detection_t det;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            det.range_mm = RANGE_W'($urandom_range(0, h + 20));
        else if (sel < 4)
            det.range_mm = RANGE_W'(h + $urandom_range(0, 3));
        else
            det.range_mm = RANGE_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            det.bearing = ANGLE_W'($urandom);
        else
            det.bearing = ANGLE_W'($urandom_range(0, 36000) - 18000);
        return det;
    endfunction

    // driver: pops pending detections, random gap after each
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready_q)
        begin
            if (gap_left > 0 || pending_dets.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, pending_dets[0]};
                expected_pts = {expected_pts, locate(pending_dets[0])};
                void'(pending_dets.pop_front());
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_q <= 1'b0;
        else
            s_tready_q <= s_tvalid && s_tready;
    end

    // sink stall, redrawn per word
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        world_pt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            stall_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
            if (expected_pts.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_pts.pop_front();
                if (m_tdata[24:0] !== want.wx)
                begin
                    $error("world_x_mm expected %0d got %0d",
                           $signed(want.wx), $signed(m_tdata[24:0]));
                    fail_count++;
                end
                if (m_tdata[49:25] !== want.wy)
                begin
                    $error("world_y_mm expected %0d got %0d",
                           $signed(want.wy), $signed(m_tdata[49:25]));
                    fail_count++;
                end
                if (m_tuser !== want.below)
                begin
                    $error("below_height expected %0d got %0d", want.below, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_MAX)
        begin
            $display("[radar_polar_to_world_xy_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        detection_t det;
        logic [OFS_W-1:0] cfg[4][4];
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        fail_count = 0;
        ofs_x = 0;
        ofs_y = 0;
        height = 4000;
        yaw = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset pose, range extremes, quadrants, wrap, clamp
        det.range_mm = 18'd0;      det.bearing = 16'sd0;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd3999;   det.bearing = 16'sd4500;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd4000;   det.bearing = -16'sd4500;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd4001;   det.bearing = 16'sd9000;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'h3FFFF;  det.bearing = 16'sd18000;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'h3FFFF;  det.bearing = -16'sd18000;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd100000; det.bearing = -16'sd9000;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd100000; det.bearing = 16'sd9001;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd100000; det.bearing = -16'sd9001;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd50000;  det.bearing = 16'h7FFF;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd50000;  det.bearing = 16'h8000;
        pending_dets = {pending_dets, det};
        det.range_mm = 18'd50000;  det.bearing = 16'hFFFF;
        pending_dets = {pending_dets, det};
        drain();

        // settings: extremes of every register and the reset values, then random ones
        cfg[0] = '{24'h7FFFFF, 24'h800000, 24'd0, 24'd0};
        cfg[1] = '{24'h800000, 24'h7FFFFF, 24'hFFFF, 24'h8000};
        cfg[2] = '{24'd0, 24'd0, 24'd0, 24'h7FFF};
        cfg[3] = '{24'd0, 24'd0, 24'd4000, 24'd0};
        for (int ph = 0; ph < 7; ph++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (ph < 4)
                    write_reg(2'(k), cfg[ph][k]);
                else if (k == REG_HEIGHT)
                    write_reg(2'(k), OFS_W'($urandom_range(0, 65535)));
                else if (k == REG_YAW)
                    write_reg(2'(k), OFS_W'($urandom_range(0, 1) ? $urandom :
                                            $urandom_range(0, 36000) - 18000));
                else
                    write_reg(2'(k), OFS_W'($urandom));
            end
            repeat (100)
                pending_dets = {pending_dets, rand_det(height)};
            drain();
        end

        if (fail_count == 0)
            $display("[radar_polar_to_world_xy_top] OK");
        else
            $display("[radar_polar_to_world_xy_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rpw_pkg.sv
rtl/rpw_sqrt_cell.sv
rtl/rpw_cordic_cell.sv
rtl/radar_polar_to_world_xy_top.sv
dv/radar_polar_to_world_xy_top_test.sv
